>>> hw/rtl/nlm_pkg.sv
// ----------------------------------------------------------------------------
// nlm_pkg
// Shared types, constants, register map and the weight table of the
// non-local means pixel filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nlm_pkg;

  localparam int DEF_MAX_WIDTH      = 64;
  localparam int DEF_MAX_HEIGHT     = 64;
  localparam int DEF_MAX_NBR_RADIUS = 7;
  localparam int DEF_MAX_CMP_RADIUS = 3;

  localparam int CHANNELS    = 3;
  localparam int RATIO_W     = 12;
  localparam int RATIO_LIMIT = 1 << RATIO_W;
  localparam int WEIGHT_W    = 16;
  localparam logic [31:0] EXP_STEP = 32'd4278222805;

  // signed coordinate width, covers the largest array plus both radii
  localparam int COORD_W = 12;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_NBR_RADIUS   = 3'd2,
    REG_CMP_RADIUS   = 3'd3,
    REG_H_SQUARED    = 3'd4
  } reg_idx_t;

  localparam logic OP_STORE  = 1'b0;
  localparam logic OP_FILTER = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NBR,
    S_PATCH,
    S_DRAIN,
    S_PROD,
    S_RLOAD,
    S_RDIV,
    S_ROM,
    S_WACC,
    S_NEXT,
    S_OLOAD,
    S_ODIV,
    S_OSTORE,
    S_OUT
  } state_t;

  typedef logic [WEIGHT_W-1:0] weight_rom_t [RATIO_LIMIT];

  // exp(-i/256) in Q0.16, built by repeated multiplication in Q0.32
  function automatic weight_rom_t build_weight_rom();
    weight_rom_t rom;
    logic [95:0] acc;
    logic [95:0] v;
    acc = 96'd1 << 32;
    for (int i = 0; i < RATIO_LIMIT; i++) begin
      v = (acc + 96'd32768) >> 16;
      rom[i] = (v > 96'd65535) ? 16'hFFFF : v[15:0];
      acc = (acc * 96'(EXP_STEP)) >> 32;
    end
    return rom;
  endfunction

  localparam weight_rom_t WEIGHT_ROM = build_weight_rom();

  function automatic logic in_range(logic signed [COORD_W-1:0] v,
                                    logic [COORD_W-1:0] lim);
    return (v >= 0) && (v < signed'(lim));
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/nlm_if.sv
// ----------------------------------------------------------------------------
// nlm_if
// Valid/ready channels of the non-local means filter: item in, result out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface nlm_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [5:0] col;
  logic [5:0] row;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, operation, col, row, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, operation, col, row, red_in, green_in, blue_in,
                output ready);
endinterface

interface nlm_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] col_out;
  logic [5:0] row_out;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, col_out, row_out, red_out, green_out, blue_out,
                  input ready);
  modport sink (input valid, col_out, row_out, red_out, green_out, blue_out,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/non_local_means_pixel_filter.sv
// ----------------------------------------------------------------------------
// non_local_means_pixel_filter
// Non-local means denoiser over an on-chip RGB frame store.
// ----------------------------------------------------------------------------
// A store transfer writes one pixel into the frame store. A filter transfer walks
// the search window one neighbour at a time: an out-of-image neighbour is skipped
// without a patch walk, an in-image one walks its (2*pr+1)^2 patch offsets, where the patch
// pixels stream from a two-read-port frame memory one offset per cycle and
// the three weight ratios go one after another through a single shared
// restoring divider (13 steps each). The final three channel divisions reuse
// that divider. The input is not ready while a filter item is in work; a
// finished result sits in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module non_local_means_pixel_filter #(
  parameter int MAX_WIDTH      = nlm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = nlm_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_NBR_RADIUS = nlm_pkg::DEF_MAX_NBR_RADIUS,
  parameter int MAX_CMP_RADIUS = nlm_pkg::DEF_MAX_CMP_RADIUS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  nlm_in_if.sink                           in_ch,
  nlm_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [nlm_pkg::PADDR_W-1:0] paddr,
  input  wire logic [nlm_pkg::PDATA_W-1:0] pwdata,
  output logic      [nlm_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);

  localparam int CW     = nlm_pkg::COORD_W;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int SOW    = $clog2(MAX_NBR_RADIUS + 1) + 1;
  localparam int POW    = $clog2(MAX_CMP_RADIUS + 1) + 1;
  localparam int NPATCH = (2 * MAX_CMP_RADIUS + 1) * (2 * MAX_CMP_RADIUS + 1);
  localparam int NNBR   = (2 * MAX_NBR_RADIUS + 1) * (2 * MAX_NBR_RADIUS + 1);
  localparam int CNT_W  = $clog2(NPATCH + 1);
  localparam int SQ_W   = $clog2(NPATCH * 65025 + 1);
  localparam int PROD_W = CNT_W + 16;
  localparam int DEN_W  = nlm_pkg::WEIGHT_W + $clog2(NNBR + 1);
  localparam int NUM_W  = DEN_W + 8;
  localparam int RQ_W   = nlm_pkg::RATIO_W + 1;
  localparam int DW_A   = (SQ_W + 8 > NUM_W) ? SQ_W + 8 : NUM_W;
  localparam int DW_B   = (PROD_W + RQ_W > DEN_W + 8) ? PROD_W + RQ_W : DEN_W + 8;
  localparam int DIV_W  = ((DW_A > DW_B) ? DW_A : DW_B) + 1;
  localparam int CH     = nlm_pkg::CHANNELS;

  // configuration registers
  logic [6:0]  image_width;
  logic [6:0]  image_height;
  logic [2:0]  nbr_radius;
  logic [1:0]  cmp_radius;
  logic [15:0] h_squared;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 7'd64;
      image_height <= 7'd64;
      nbr_radius   <= 3'd3;
      cmp_radius   <= 2'd1;
      h_squared    <= 16'd100;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        nlm_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[6:0];
        nlm_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[6:0];
        nlm_pkg::REG_NBR_RADIUS:   nbr_radius   <= pwdata[2:0];
        nlm_pkg::REG_CMP_RADIUS:   cmp_radius   <= pwdata[1:0];
        nlm_pkg::REG_H_SQUARED:    h_squared    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      nlm_pkg::REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      nlm_pkg::REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      nlm_pkg::REG_NBR_RADIUS:   prdata = 32'(nbr_radius);
      nlm_pkg::REG_CMP_RADIUS:   prdata = 32'(cmp_radius);
      nlm_pkg::REG_H_SQUARED:    prdata = 32'(h_squared);
      default:                   prdata = '0;
    endcase
  end

  // clamped geometry
  logic [CW-1:0]        w_lim, h_lim;
  logic [3:0]           sr_u;
  logic [2:0]           pr_u;
  logic signed [CW-1:0] sr_c, pr_c;
  logic [15:0]          hs;

  assign w_lim = (CW'(image_width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(image_width);
  assign h_lim = (CW'(image_height) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT)
                                                        : CW'(image_height);
  assign sr_u  = (4'(nbr_radius) > 4'(MAX_NBR_RADIUS)) ? 4'(MAX_NBR_RADIUS)
                                                        : 4'(nbr_radius);
  assign pr_u  = (3'(cmp_radius) > 3'(MAX_CMP_RADIUS)) ? 3'(MAX_CMP_RADIUS)
                                                        : 3'(cmp_radius);
  assign sr_c  = signed'(CW'(sr_u));
  assign pr_c  = signed'(CW'(pr_u));
  assign hs    = (h_squared == 16'd0) ? 16'd1 : h_squared;

  // sequencer state and datapath registers
  nlm_pkg::state_t state, state_next;

  logic [5:0]            col_r, row_r;
  logic signed [SOW-1:0] dy, dx;
  logic signed [POW-1:0] py, px;
  logic [CNT_W-1:0]      cnt;
  logic [SQ_W-1:0]       sumsq [CH];
  logic [NUM_W-1:0]      num   [CH];
  logic [DEN_W-1:0]      den   [CH];
  logic [7:0]            res   [CH];
  logic [1:0]            ch;
  logic                  rd_vld;
  logic                  ctr_cap;
  logic [23:0]           ctr_pix;
  logic [PROD_W-1:0]     prod;
  logic [DIV_W-1:0]      div_rem, div_dsh;
  logic [RQ_W-1:0]       div_q;
  logic [3:0]            div_step;
  logic [nlm_pkg::WEIGHT_W-1:0] rom_q;
  logic                  wt_zero;
  logic                  out_valid;
  logic [5:0]            col_o, row_o;
  logic [7:0]            red_o, green_o, blue_o;

  // coordinates of the current neighbour and patch offset
  logic signed [CW-1:0] col_c, row_c, dx_c, dy_c, px_c, py_c;
  logic signed [CW-1:0] nx, ny, ax, ay, bx, by;
  logic                 nbr_in, pat_in, last_patch, last_nbr;

  assign col_c = signed'(CW'(col_r));
  assign row_c = signed'(CW'(row_r));
  assign dx_c  = CW'(dx);
  assign dy_c  = CW'(dy);
  assign px_c  = CW'(px);
  assign py_c  = CW'(py);
  assign nx    = col_c + dx_c;
  assign ny    = row_c + dy_c;
  assign ax    = col_c + px_c;
  assign ay    = row_c + py_c;
  assign bx    = nx + px_c;
  assign by    = ny + py_c;

  assign nbr_in = nlm_pkg::in_range(nx, w_lim) && nlm_pkg::in_range(ny, h_lim);
  assign pat_in = nlm_pkg::in_range(ax, w_lim) && nlm_pkg::in_range(ay, h_lim) &&
                  nlm_pkg::in_range(bx, w_lim) && nlm_pkg::in_range(by, h_lim);
  assign last_patch = (px_c == pr_c) && (py_c == pr_c);
  assign last_nbr   = (dx_c == sr_c) && (dy_c == sr_c);

  // frame store: one write port, two registered read ports
  logic [23:0]   frame_mem [DEPTH];
  logic [AW-1:0] wr_addr, addr_a, addr_b;
  logic [23:0]   rd_a, rd_b;
  logic          in_fire, mem_we;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign mem_we  = in_fire && (in_ch.operation == nlm_pkg::OP_STORE) &&
                   (32'(in_ch.col) < 32'(MAX_WIDTH)) && (32'(in_ch.row) < 32'(MAX_HEIGHT));
  assign wr_addr = AW'(in_ch.row) * AW'(MAX_WIDTH) + AW'(in_ch.col);
  assign addr_a  = AW'(ay[YW-1:0]) * AW'(MAX_WIDTH) + AW'(ax[XW-1:0]);
  assign addr_b  = (state == nlm_pkg::S_NBR)
                 ? AW'(ny[YW-1:0]) * AW'(MAX_WIDTH) + AW'(nx[XW-1:0])
                 : AW'(by[YW-1:0]) * AW'(MAX_WIDTH) + AW'(bx[XW-1:0]);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[wr_addr] <= {in_ch.blue_in, in_ch.green_in, in_ch.red_in};
    end
    rd_a <= frame_mem[addr_a];
    rd_b <= frame_mem[addr_b];
  end

  // squared channel differences of the pixel pair read last cycle
  logic [15:0] sq [CH];
  always_comb begin
    for (int c = 0; c < CH; c++) begin
      logic [7:0] a, b, d;
      a = rd_a[8*c +: 8];
      b = rd_b[8*c +: 8];
      d = (a > b) ? a - b : b - a;
      sq[c] = 16'(d) * 16'(d);
    end
  end

  // shared restoring divider step
  logic div_ge;
  assign div_ge = div_rem >= div_dsh;

  // weight table read
  logic [nlm_pkg::RATIO_W-1:0] rom_addr;
  assign rom_addr = (cnt == '0) ? '0 : div_q[nlm_pkg::RATIO_W-1:0];
  always_ff @(posedge clk) begin
    rom_q <= nlm_pkg::WEIGHT_ROM[rom_addr];
  end

  logic [7:0]  pix_sel;
  logic [nlm_pkg::WEIGHT_W-1:0] wt;
  logic [23:0] wp;
  assign pix_sel = ctr_pix[{ch, 3'b000} +: 8];
  assign wt      = wt_zero ? '0 : rom_q;
  assign wp      = 24'(wt) * 24'(pix_sel);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nlm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    unique case (state)
      nlm_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_fire && (in_ch.operation == nlm_pkg::OP_FILTER)) begin
          state_next = nlm_pkg::S_NBR;
        end
      end
      nlm_pkg::S_NBR:    state_next = nbr_in ? nlm_pkg::S_PATCH : nlm_pkg::S_NEXT;
      nlm_pkg::S_PATCH:  state_next = last_patch ? nlm_pkg::S_DRAIN : nlm_pkg::S_PATCH;
      nlm_pkg::S_DRAIN:  state_next = nlm_pkg::S_PROD;
      nlm_pkg::S_PROD:   state_next = nlm_pkg::S_RLOAD;
      nlm_pkg::S_RLOAD:  state_next = nlm_pkg::S_RDIV;
      nlm_pkg::S_RDIV:   state_next = (div_step == 4'd0) ? nlm_pkg::S_ROM : nlm_pkg::S_RDIV;
      nlm_pkg::S_ROM:    state_next = nlm_pkg::S_WACC;
      nlm_pkg::S_WACC:   state_next = (ch == 2'd2) ? nlm_pkg::S_NEXT : nlm_pkg::S_RLOAD;
      nlm_pkg::S_NEXT:   state_next = last_nbr ? nlm_pkg::S_OLOAD : nlm_pkg::S_NBR;
      nlm_pkg::S_OLOAD:  state_next = nlm_pkg::S_ODIV;
      nlm_pkg::S_ODIV:   state_next = (div_step == 4'd0) ? nlm_pkg::S_OSTORE
                                                         : nlm_pkg::S_ODIV;
      nlm_pkg::S_OSTORE: state_next = (ch == 2'd2) ? nlm_pkg::S_OUT : nlm_pkg::S_OLOAD;
      nlm_pkg::S_OUT: begin
        if (!out_valid || out_ch.ready) begin
          state_next = nlm_pkg::S_IDLE;
        end
      end
      default: state_next = nlm_pkg::S_IDLE;
    endcase
  end

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld    <= 1'b0;
      ctr_cap   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld  <= (state == nlm_pkg::S_PATCH) && pat_in;
      ctr_cap <= (state == nlm_pkg::S_NBR) && nbr_in;
      if (state == nlm_pkg::S_OUT && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctr_cap) begin
      ctr_pix <= rd_b;
    end
    if (rd_vld) begin
      for (int c = 0; c < CH; c++) begin
        sumsq[c] <= sumsq[c] + SQ_W'(sq[c]);
      end
      cnt <= cnt + 1'b1;
    end

    unique case (state)
      nlm_pkg::S_IDLE: begin
        if (in_fire) begin
          col_r <= in_ch.col;
          row_r <= in_ch.row;
          dx    <= SOW'(-sr_c);
          dy    <= SOW'(-sr_c);
          for (int c = 0; c < CH; c++) begin
            num[c] <= '0;
            den[c] <= '0;
          end
        end
      end
      nlm_pkg::S_NBR: begin
        px  <= POW'(-pr_c);
        py  <= POW'(-pr_c);
        cnt <= '0;
        for (int c = 0; c < CH; c++) begin
          sumsq[c] <= '0;
        end
      end
      nlm_pkg::S_PATCH: begin
        if (px_c == pr_c) begin
          px <= POW'(-pr_c);
          py <= py + 1'b1;
        end else begin
          px <= px + 1'b1;
        end
      end
      nlm_pkg::S_PROD: begin
        prod <= PROD_W'(cnt) * PROD_W'(hs);
        ch   <= 2'd0;
      end
      nlm_pkg::S_RLOAD: begin
        div_rem  <= DIV_W'(sumsq[ch]) << 8;
        div_dsh  <= DIV_W'(prod) << nlm_pkg::RATIO_W;
        div_q    <= '0;
        div_step <= 4'(nlm_pkg::RATIO_W);
      end
      nlm_pkg::S_RDIV, nlm_pkg::S_ODIV: begin
        if (div_ge) begin
          div_rem <= div_rem - div_dsh;
        end
        div_dsh  <= div_dsh >> 1;
        div_q    <= {div_q[RQ_W-2:0], div_ge};
        div_step <= div_step - 1'b1;
      end
      nlm_pkg::S_ROM: begin
        // ratio of 16 or more gives no weight
        wt_zero <= (cnt != '0) && div_q[nlm_pkg::RATIO_W];
      end
      nlm_pkg::S_WACC: begin
        num[ch] <= num[ch] + NUM_W'(wp);
        den[ch] <= den[ch] + DEN_W'(wt);
        ch      <= ch + 1'b1;
      end
      nlm_pkg::S_NEXT: begin
        ch <= 2'd0;
        if (dx_c == sr_c) begin
          dx <= SOW'(-sr_c);
          dy <= dy + 1'b1;
        end else begin
          dx <= dx + 1'b1;
        end
      end
      nlm_pkg::S_OLOAD: begin
        div_rem  <= DIV_W'(num[ch]);
        div_dsh  <= DIV_W'(den[ch]) << 7;
        div_q    <= '0;
        div_step <= 4'd7;
      end
      nlm_pkg::S_OSTORE: begin
        res[ch] <= (den[ch] == '0) ? 8'd0 : div_q[7:0];
        ch      <= ch + 1'b1;
      end
      nlm_pkg::S_OUT: begin
        if (!out_valid || out_ch.ready) begin
          col_o   <= col_r;
          row_o   <= row_r;
          red_o   <= res[0];
          green_o <= res[1];
          blue_o  <= res[2];
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.col_out   = col_o;
  assign out_ch.row_out   = row_o;
  assign out_ch.red_out   = red_o;
  assign out_ch.green_out = green_o;
  assign out_ch.blue_out  = blue_o;

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == nlm_pkg::S_IDLE)
    else $error("input ready outside idle");

  a_rd_after_patch: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state) == nlm_pkg::S_PATCH)
    else $error("patch read valid without a patch cycle");

  a_cap_after_nbr: assert property (@(posedge clk) disable iff (rst)
    ctr_cap |-> state == nlm_pkg::S_PATCH)
    else $error("center capture outside patch walk");

  a_idle_no_read: assert property (@(posedge clk) disable iff (rst)
    state == nlm_pkg::S_IDLE |-> !rd_vld && !ctr_cap)
    else $error("pending read in idle");
`endif

endmodule

`default_nettype wire

>>> tb/nlm_tb_if.sv
// ----------------------------------------------------------------------------
// nlm_tb_if
// Testbench-side copies of the pixel item and filtered result records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nlm_tb_pkg;

  typedef struct packed {
    logic       operation;
    logic [5:0] col;
    logic [5:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_item_t;

  typedef struct packed {
    logic [5:0] col;
    logic [5:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } filtered_px_t;

endpackage

>>> tb/non_local_means_pixel_filter_test.sv
// ----------------------------------------------------------------------------
// non_local_means_pixel_filter_test
// Drives pixel store and filter transfers through several image geometries,
// radii and filter strengths, predicts each filtered pixel with an
// independent non-local means calculation and compares every result field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module non_local_means_pixel_filter_test;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int SETTLE = 40;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [nlm_pkg::PADDR_W-1:0] paddr;
  logic [nlm_pkg::PDATA_W-1:0] pwdata;
  logic [nlm_pkg::PDATA_W-1:0] prdata;
  logic pready;

  nlm_in_if in_if ();
  nlm_out_if out_if ();

  non_local_means_pixel_filter dut (
    .clk(clk), .rst(rst), .in_ch(in_if.sink), .out_ch(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [15:0] exp_weight [nlm_pkg::RATIO_LIMIT];
  logic [23:0] frame_mem [4096];
  int img_w, img_h, srch_r, ptch_r, h_sq;

  nlm_tb_pkg::pixel_item_t pending_items[$];
  nlm_tb_pkg::filtered_px_t expected_px[$];
  int errors;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [7:0] chan(int c, int r, int ch);
    logic [23:0] v;
    v = frame_mem[r * 64 + c];
    return v[8*ch +: 8];
  endfunction

  function automatic nlm_tb_pkg::filtered_px_t nlm_filter(int c, int r);
    int w, h, sr, pr, nx, ny, ax, ay, bx, by, cnt, ch, d;
    longint unsigned hs, ratio, wt;
    longint unsigned num [3], den [3], sumsq [3];
    nlm_tb_pkg::filtered_px_t res;
    w = img_w > 64 ? 64 : img_w;
    h = img_h > 64 ? 64 : img_h;
    sr = srch_r;
    pr = ptch_r;
    hs = h_sq == 0 ? 1 : h_sq;
    for (ch = 0; ch < 3; ch++) begin
      num[ch] = 0;
      den[ch] = 0;
    end
    for (int dy = -sr; dy <= sr; dy++) begin
      for (int dx = -sr; dx <= sr; dx++) begin
        nx = c + dx;
        ny = r + dy;
        if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
        cnt = 0;
        for (ch = 0; ch < 3; ch++) sumsq[ch] = 0;
        for (int py = -pr; py <= pr; py++) begin
          for (int px = -pr; px <= pr; px++) begin
            ax = c + px; ay = r + py; bx = nx + px; by = ny + py;
            if (ax < 0 || ay < 0 || bx < 0 || by < 0 ||
                ax >= w || ay >= h || bx >= w || by >= h) continue;
            for (ch = 0; ch < 3; ch++) begin
              d = int'(chan(ax, ay, ch)) - int'(chan(bx, by, ch));
              sumsq[ch] += longint'(d * d);
            end
            cnt++;
          end
        end
        for (ch = 0; ch < 3; ch++) begin
          ratio = cnt > 0 ? (sumsq[ch] * 256) / (longint'(cnt) * hs) : 0;
          wt = ratio < nlm_pkg::RATIO_LIMIT ? exp_weight[ratio] : 0;
          num[ch] += wt * chan(nx, ny, ch);
          den[ch] += wt;
        end
      end
    end
    res.col = c[5:0];
    res.row = r[5:0];
    res.red   = den[0] == 0 ? 8'd0 : 8'(num[0] / den[0]);
    res.green = den[1] == 0 ? 8'd0 : 8'(num[1] / den[1]);
    res.blue  = den[2] == 0 ? 8'd0 : 8'(num[2] / den[2]);
    return res;
  endfunction

  // sender: bursts with random gaps, predicts at each accepted transfer
  int burst_left, gap_left;
  always @(posedge clk) begin
    nlm_tb_pkg::pixel_item_t it;
    logic take;
    if (rst) begin
      in_if.valid <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      take = in_if.valid && in_if.ready;
      if (take) begin
        it = pending_items.pop_front();
        if (it.operation == nlm_pkg::OP_STORE)
          frame_mem[it.row * 64 + it.col] = {it.blue, it.green, it.red};
        else
          expected_px.push_back(nlm_filter(it.col, it.row));
      end
      if (!(in_if.valid && !take)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() > 0 && !(take && burst_left == 1)) begin
          it = pending_items[0];
          in_if.valid <= 1'b1;
          in_if.operation <= it.operation;
          in_if.col <= it.col;
          in_if.row <= it.row;
          in_if.red_in <= it.red;
          in_if.green_in <= it.green;
          in_if.blue_in <= it.blue;
        end else begin
          in_if.valid <= 1'b0;
        end
        if (take) begin
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver: stall runs of random length
  int stall_left;
  always @(posedge clk) begin
    nlm_tb_pkg::filtered_px_t got, want;
    if (rst) begin
      out_if.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.col_out, out_if.row_out, out_if.red_out, out_if.green_out,
                out_if.blue_out};
        if (expected_px.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = expected_px.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 40);
      end
    end
  end

  task automatic write_reg(nlm_pkg::reg_idx_t idx, int value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      nlm_pkg::REG_IMAGE_WIDTH:  img_w = value & 8'h7F;
      nlm_pkg::REG_IMAGE_HEIGHT: img_h = value & 8'h7F;
      nlm_pkg::REG_NBR_RADIUS:   srch_r = value & 7;
      nlm_pkg::REG_CMP_RADIUS:   ptch_r = value & 3;
      nlm_pkg::REG_H_SQUARED:    h_sq = value & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic set_geometry(int w, int h, int sr, int pr, int hs);
    write_reg(nlm_pkg::REG_IMAGE_WIDTH, w);
    write_reg(nlm_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(nlm_pkg::REG_NBR_RADIUS, sr);
    write_reg(nlm_pkg::REG_CMP_RADIUS, pr);
    write_reg(nlm_pkg::REG_H_SQUARED, hs);
  endtask

  task automatic push_store(int c, int r, logic [23:0] rgb);
    pending_items.push_back('{nlm_pkg::OP_STORE, c[5:0], r[5:0], rgb[7:0], rgb[15:8],
                              rgb[23:16]});
  endtask

  task automatic push_filter(int c, int r);
    pending_items.push_back('{nlm_pkg::OP_FILTER, c[5:0], r[5:0], 8'($urandom),
                              8'($urandom), 8'($urandom)});
  endtask

  // every pixel of the active image gets written before any filter reads it
  task automatic fill_image();
    int w, h;
    w = img_w > 64 ? 64 : img_w;
    h = img_h > 64 ? 64 : img_h;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) push_store(c, r, 24'($urandom));
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_px.size() > 0 || in_if.valid)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_mix(int n);
    int w, h;
    w = img_w > 64 ? 64 : img_w;
    h = img_h > 64 ? 64 : img_h;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 19)) inside
        [0:4]: push_store($urandom_range(0, 63), $urandom_range(0, 63), 24'($urandom));
        [5:7]: push_filter($urandom_range(0, 63), $urandom_range(0, 63));
        default: push_filter($urandom_range(0, w - 1), $urandom_range(0, h - 1));
      endcase
    end
  endtask

  initial begin
    logic [95:0] acc, v;
    acc = 96'd1 << 32;
    for (int i = 0; i < nlm_pkg::RATIO_LIMIT; i++) begin
      v = (acc + 96'd32768) >> 16;
      exp_weight[i] = v > 96'd65535 ? 16'hFFFF : v[15:0];
      acc = (acc * 96'd4278222805) >> 32;
    end
    for (int i = 0; i < 4096; i++) frame_mem[i] = '0;
    img_w = 64; img_h = 64; srch_r = 3; ptch_r = 1; h_sq = 100;
    errors = 0;
    cycles = 0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_if.valid = 1'b0; in_if.operation = nlm_pkg::OP_STORE; in_if.col = '0;
    in_if.row = '0;
    in_if.red_in = '0; in_if.green_in = '0; in_if.blue_in = '0;
    out_if.ready = 1'b0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: tiny image, flat and saturated corners, filters outside the image
    set_geometry(4, 4, 1, 1, 100);
    fill_image();
    push_store(0, 0, 24'h000000);
    push_store(3, 3, 24'hFFFFFF);
    push_store(63, 63, 24'hA55AC3);
    push_filter(0, 0);
    push_filter(3, 3);
    push_filter(1, 2);
    push_filter(3, 0);
    push_filter(63, 63);
    push_filter(4, 1);
    drain();

    // oversized width clamps, single row, widest radii, largest h squared
    set_geometry(127, 1, 7, 3, 65535);
    fill_image();
    for (int k = 0; k < 8; k++) push_filter($urandom_range(0, 63), 0);
    push_filter(63, 0);
    drain();

    // single column, zero radii, zero strength acting as one
    set_geometry(1, 64, 0, 0, 0);
    fill_image();
    for (int k = 0; k < 6; k++) push_filter(0, $urandom_range(0, 63));
    drain();

    // zero size leaves nothing in bounds
    set_geometry(0, 64, 3, 1, 1);
    push_store(17, 40, 24'($urandom));
    push_filter(0, 0);
    push_filter(10, 20);
    drain();

    for (int p = 0; p < 3; p++) begin
      set_geometry($urandom_range(3, 7), $urandom_range(3, 7), $urandom_range(0, 7),
                   $urandom_range(0, 3),
                   p == 0 ? 1 : $urandom_range(1, 2000));
      fill_image();
      random_mix(12);
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
